// ----- rtl/core/nfha_pkg.sv -----
// ============================================================================
// nfha_pkg
// Shared constants and types for the next-fit heap allocator.
// ============================================================================
package nfha_pkg;

  // Heap geometry.
  localparam int HEAP_WORDS   = 1024;
  localparam int HEADER_WORDS = 3;
  localparam int ADDR_W       = $clog2(HEAP_WORDS);
  localparam int SIZE_W       = ADDR_W + 1;
  // Walk position and run length can step past the heap end.
  localparam int WALK_W       = SIZE_W + 1;

  // Transaction field widths.
  localparam int ACTION_W    = 2;
  localparam int OBJ_SIZE_W  = 11;
  localparam int TAG_W       = 8;
  localparam int FREE_ADDR_W = 10;
  localparam int OBJ_ADDR_W  = 10;
  localparam int GRANT_W     = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

endpackage

// ----- rtl/core/nfha_if.sv -----
// ============================================================================
// nfha_req_if / nfha_rsp_if
// Valid/ready channels for allocator requests and results.
// ============================================================================
interface nfha_req_if;
  logic                                valid;
  logic                                ready;
  logic [nfha_pkg::ACTION_W-1:0]       action;
  logic [nfha_pkg::OBJ_SIZE_W-1:0]     object_size;
  logic [nfha_pkg::TAG_W-1:0]          type_tag;
  logic [nfha_pkg::FREE_ADDR_W-1:0]    free_address;

  modport source (output valid, action, object_size, type_tag, free_address,
                  input ready);
  modport sink   (input valid, action, object_size, type_tag, free_address,
                  output ready);
endinterface

interface nfha_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                granted;
  logic [nfha_pkg::OBJ_ADDR_W-1:0]     object_address;
  logic [nfha_pkg::GRANT_W-1:0]        granted_size;

  modport source (output valid, granted, object_address, granted_size,
                  input ready);
  modport sink   (input valid, granted, object_address, granted_size,
                  output ready);
endinterface

// ----- rtl/core/next_fit_heap_allocator_top.sv -----
// ============================================================================
// next_fit_heap_allocator_top
// Next-fit allocator walking a chain of chunk headers held in on-chip memory.
// ============================================================================
//
//  Channel | Dir | Payload                                    | Handshake
//  --------+-----+--------------------------------------------+------------
//  req     | in  | action, object_size, type_tag, free_address| valid/ready
//  rsp     | out | granted, object_address, granted_size      | valid/ready
//
// Free and restart do their work in the accepting cycle; the result is offered
// in the next. Allocate visits each chunk header in a read step (S_READ on the
// header memories) and an evaluate step (S_EVAL), then splits (S_SPLIT) and
// commits (S_COMMIT) a fit, then the result.
// Reset clears the sequencer and the search position; no memory sweep runs,
// the header at address zero reads as one free heap-sized chunk until written.
// A stalled result holds the block; req.ready is high only when idle.
//
// Every transaction produces exactly one result. The walk merges each run of
// adjacent free chunks into the first header of the run as it goes, writing
// the growing length back as it evaluates each further free chunk.
// ============================================================================
module next_fit_heap_allocator_top (
  input  logic       clk,
  input  logic       rst,
  nfha_req_if.sink   req,
  nfha_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SPLIT,
    S_COMMIT,
    S_RESP
  } state_t;

  state_t state;

  // Walk registers.
  logic [nfha_pkg::WALK_W-1:0]     cur;
  logic [nfha_pkg::ADDR_W-1:0]     base;
  logic [nfha_pkg::WALK_W-1:0]     run;
  logic                            have_run;
  logic [nfha_pkg::OBJ_SIZE_W-1:0] want;
  logic [nfha_pkg::TAG_W-1:0]      tag;

  // Search position.
  logic [nfha_pkg::ADDR_W-1:0]     pos;
  logic                            pos_valid;

  // Header memories. Address zero is backed by reset-cleared flags so that it
  // reads as the initial free chunk until first written.
  logic [nfha_pkg::TAG_W-1:0]  tag_mem  [nfha_pkg::HEAP_WORDS];
  logic [nfha_pkg::SIZE_W-1:0] size_mem [nfha_pkg::HEAP_WORDS];
  logic [nfha_pkg::TAG_W-1:0]  tag_rdata;
  logic [nfha_pkg::SIZE_W-1:0] size_rdata;
  logic                        rd_zero;
  logic                        tag0_ok;
  logic                        size0_ok;

  logic                        tag_we;
  logic [nfha_pkg::ADDR_W-1:0] tag_waddr;
  logic [nfha_pkg::TAG_W-1:0]  tag_wdata;
  logic                        size_we;
  logic [nfha_pkg::ADDR_W-1:0] size_waddr;
  logic [nfha_pkg::SIZE_W-1:0] size_wdata;
  logic [nfha_pkg::ADDR_W-1:0] rd_addr;

  // Result register.
  logic                            out_valid;
  logic                            out_granted;
  logic [nfha_pkg::OBJ_ADDR_W-1:0] out_addr;
  logic [nfha_pkg::GRANT_W-1:0]    out_size;

  logic req_fire;
  logic rsp_fire;

  // Header as seen by the evaluate step.
  logic [nfha_pkg::TAG_W-1:0]  hdr_tag;
  logic [nfha_pkg::SIZE_W-1:0] hdr_size;
  logic                        hdr_free;
  logic [nfha_pkg::WALK_W-1:0] hdr_size_ext;
  logic [nfha_pkg::WALK_W-1:0] run_n;
  logic [nfha_pkg::WALK_W-1:0] want_ext;
  logic                        fit;
  logic [nfha_pkg::WALK_W-1:0] cur_sum;

  // Split step.
  logic [nfha_pkg::WALK_W-1:0] leftover;
  logic                        do_split;
  logic [nfha_pkg::WALK_W-1:0] next_hdr;
  logic                        next_in_heap;

  // Free request decode.
  logic free_in_heap;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.granted        = out_granted;
  assign rsp.object_address = out_addr;
  assign rsp.granted_size   = out_size;

  assign rd_addr = cur[nfha_pkg::ADDR_W-1:0];

  assign hdr_tag      = (rd_zero && !tag0_ok) ? '0 : tag_rdata;
  assign hdr_size     = (rd_zero && !size0_ok) ?
                        nfha_pkg::SIZE_W'(nfha_pkg::HEAP_WORDS) : size_rdata;
  assign hdr_free     = (hdr_tag == '0);
  assign hdr_size_ext = nfha_pkg::WALK_W'(hdr_size);
  assign want_ext     = nfha_pkg::WALK_W'(want);

  // A free header either opens a run or extends the current one.
  assign run_n   = !hdr_free ? run : (have_run ? run + hdr_size_ext : hdr_size_ext);
  assign fit     = hdr_free && (run_n >= want_ext);
  assign cur_sum = cur + hdr_size_ext;

  assign leftover     = run - want_ext;
  assign do_split     = (leftover >= nfha_pkg::WALK_W'(nfha_pkg::HEADER_WORDS));
  assign next_hdr     = nfha_pkg::WALK_W'(base) + want_ext;
  assign next_in_heap = (next_hdr < nfha_pkg::WALK_W'(nfha_pkg::HEAP_WORDS));

  assign free_in_heap = ({1'b0, req.free_address} <
                         (nfha_pkg::FREE_ADDR_W + 1)'(nfha_pkg::HEAP_WORDS));

  // Memory write port selection by sequencer step.
  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = base;
    tag_wdata  = '0;
    size_we    = 1'b0;
    size_waddr = base;
    size_wdata = '0;
    case (state)
      S_IDLE: begin
        if (req_fire && (req.action == nfha_pkg::ACT_FREE) && free_in_heap) begin
          tag_we    = 1'b1;
          tag_waddr = nfha_pkg::ADDR_W'(req.free_address);
        end
      end
      S_EVAL: begin
        size_we    = hdr_free && have_run;
        size_wdata = run_n[nfha_pkg::SIZE_W-1:0];
      end
      S_SPLIT: begin
        if (do_split && next_in_heap) begin
          tag_we     = 1'b1;
          tag_waddr  = next_hdr[nfha_pkg::ADDR_W-1:0];
          size_we    = 1'b1;
          size_waddr = next_hdr[nfha_pkg::ADDR_W-1:0];
          size_wdata = leftover[nfha_pkg::SIZE_W-1:0];
        end
      end
      S_COMMIT: begin
        tag_we     = 1'b1;
        tag_wdata  = tag;
        size_we    = 1'b1;
        size_wdata = nfha_pkg::SIZE_W'(want);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rdata <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rdata <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_zero <= (rd_addr == '0);
    if (rst) begin
      tag0_ok  <= 1'b0;
      size0_ok <= 1'b0;
    end else begin
      if (tag_we && (tag_waddr == '0)) begin
        tag0_ok <= 1'b1;
      end
      if (size_we && (size_waddr == '0)) begin
        size0_ok <= 1'b1;
      end
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      pos_valid   <= 1'b1;
      have_run    <= 1'b0;
      out_valid   <= 1'b0;
      out_granted <= 1'b0;
      out_addr    <= '0;
      out_size    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            out_granted <= 1'b0;
            out_addr    <= '0;
            out_size    <= '0;
            want        <= req.object_size;
            tag         <= req.type_tag;
            have_run    <= 1'b0;
            run         <= '0;
            cur         <= pos_valid ? nfha_pkg::WALK_W'(pos) : '0;
            state       <= S_RESP;
            out_valid   <= 1'b1;
            case (req.action)
              nfha_pkg::ACT_ALLOC: begin
                // A zero request fails without touching the heap.
                if (req.object_size != '0) begin
                  state     <= S_READ;
                  out_valid <= 1'b0;
                end
              end
              nfha_pkg::ACT_FREE: begin
                if (free_in_heap && pos_valid &&
                    (nfha_pkg::ADDR_W'(req.free_address) < pos)) begin
                  pos <= nfha_pkg::ADDR_W'(req.free_address);
                end
              end
              nfha_pkg::ACT_RESTART: begin
                pos_valid <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          have_run <= hdr_free;
          if (hdr_free && !have_run) begin
            base <= cur[nfha_pkg::ADDR_W-1:0];
          end
          run <= run_n;
          // After a restart, the first free chunk met becomes the position.
          if (hdr_free && !pos_valid) begin
            pos       <= cur[nfha_pkg::ADDR_W-1:0];
            pos_valid <= 1'b1;
          end
          if (fit) begin
            state <= S_SPLIT;
          end else if ((hdr_size == '0) ||
                       (cur_sum >= nfha_pkg::WALK_W'(nfha_pkg::HEAP_WORDS))) begin
            state     <= S_RESP;
            out_valid <= 1'b1;
          end else begin
            cur   <= cur_sum;
            state <= S_READ;
          end
        end
        S_SPLIT: begin
          if (do_split) begin
            if (next_in_heap) begin
              pos       <= next_hdr[nfha_pkg::ADDR_W-1:0];
              pos_valid <= 1'b1;
            end
          end else begin
            // Leftover too small for a header: grant the whole run.
            want <= run[nfha_pkg::OBJ_SIZE_W-1:0];
          end
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          out_granted <= 1'b1;
          out_addr    <= nfha_pkg::OBJ_ADDR_W'(base);
          out_size    <= nfha_pkg::GRANT_W'(want);
          out_valid   <= 1'b1;
          state       <= S_RESP;
        end
        S_RESP: begin
          if (rsp_fire) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/nfha_checker.sv -----
// ============================================================================
// nfha_checker
// Port-level assertions for the next-fit heap allocator.
// ============================================================================
module nfha_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic                                rsp_granted,
  input logic [nfha_pkg::OBJ_ADDR_W-1:0]     rsp_object_address,
  input logic [nfha_pkg::GRANT_W-1:0]        rsp_granted_size
);

  // One transaction is worked at a time: acceptance drops ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while a transaction is in flight");

  // No new request is taken while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("ready raised while a result is pending");

  // A pending result holds until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_granted) &&
      $stable(rsp_object_address) && $stable(rsp_granted_size)))
    else $error("result changed while stalled");

  // A refused transaction reports zero address and size.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_granted) |-> ((rsp_object_address == '0) &&
      (rsp_granted_size == '0)))
    else $error("refused result carries a nonzero field");

  // A grant always hands out at least one word.
  a_grant_nonempty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_granted) |-> (rsp_granted_size != '0))
    else $error("grant of zero words");

endmodule

bind next_fit_heap_allocator_top nfha_checker u_nfha_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_granted        (rsp.granted),
  .rsp_object_address (rsp.object_address),
  .rsp_granted_size   (rsp.granted_size)
);
